>>> src/skt_pkg.sv
// Shared types, command codes and the ordering-key function for the sorted key table.
// Used by the top level and the testbench; depends on nothing else.
`default_nettype none

package skt_pkg;

    localparam int KEY_W  = 32;
    localparam int PAY_W  = 32;
    localparam int WORD_W = KEY_W + PAY_W;
    localparam int ORD_W  = 33;
    localparam int OUT_IDX_W = 9;

    localparam logic [1:0] CMD_LOOKUP = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef logic signed [ORD_W-1:0] ord_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_EXEC,
        ST_SHIFT,
        ST_TAIL,
        ST_WRNEW,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        PH_HALVE,
        PH_LOW,
        PH_HIGH
    } phase_t;

    function automatic ord_t order_of(input logic [KEY_W-1:0] k);
        ord_t v;
        v = ORD_W'({2'b00, k[KEY_W-2:0]});
        return k[KEY_W-1] ? -v : v;
    endfunction

endpackage

`default_nettype wire

>>> src/skt_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// Holds the table entries; has no dependencies.
`default_nettype none

module skt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> src/sorted_key_table_search_insert_remove_unit.sv
// Sorted key table with binary search, insert and remove over one entry RAM.
// Depends on skt_pkg and skt_ram.
//
// Usage: an input transaction (cmd, cell_key, entry_payload) is taken when in_valid is high
// and in_stall is low. Each input transaction yields exactly one output transaction
// (found, position, payload_out, entry_count, status), offered on out_valid and held
// while out_stall is high. The unit works on one transaction at a time; in_stall is low
// only while it is idle, and it may take the next transaction while a result still waits.
// A search reads the table RAM once per probe, about log2(entry_count) + 3 probes,
// the first at the index of the last hit while that is below entry_count, else at the
// middle. An insert or a remove then moves one entry per cycle through the RAM ports,
// up to entry_count entries. The result leaves as soon as the output register is free,
// so a stalled receiver holds the unit in its last step.
// Reset clears the entry count and the search hint; the RAM contents are not cleared
// and no entry is read before it is written.
`default_nettype none

module sorted_key_table_search_insert_remove_unit #(
    parameter int CAPACITY = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  cmd,
    input  wire logic [31:0] cell_key,
    input  wire logic [31:0] entry_payload,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             found,
    output logic [8:0]       position,
    output logic [31:0]      payload_out,
    output logic [8:0]       entry_count,
    output logic             status
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    skt_pkg::state_t state_reg, state_next;
    skt_pkg::phase_t phase_reg, phase_next;

    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] last_hit_reg, last_hit_next;
    logic          hint_valid_reg, hint_valid_next;

    logic [1:0]    cmd_reg, cmd_next;
    logic [31:0]   key_reg, key_next;
    logic [31:0]   pay_reg, pay_next;
    skt_pkg::ord_t target_reg, target_next;

    logic [AW-1:0] lo_reg, lo_next;
    logic [AW-1:0] hi_reg, hi_next;
    logic [AW-1:0] cur_reg, cur_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic          hit_reg, hit_next;
    logic [31:0]   hit_pay_reg, hit_pay_next;
    logic          status_reg, status_next;

    logic [AW-1:0] sh_ptr_reg, sh_ptr_next;
    logic [AW-1:0] sh_end_reg, sh_end_next;
    logic [AW-1:0] sh_prev_reg, sh_prev_next;
    logic          sh_pend_reg, sh_pend_next;

    logic          out_valid_reg, out_valid_next;
    logic          found_reg, found_next;
    logic [8:0]    position_reg, position_next;
    logic [31:0]   payload_out_reg, payload_out_next;
    logic [8:0]    entry_count_reg, entry_count_next;
    logic          status_out_reg, status_out_next;

    logic                      ram_wr_en, ram_rd_en;
    logic [AW-1:0]             ram_wr_addr, ram_rd_addr;
    logic [skt_pkg::WORD_W-1:0] ram_wr_data, ram_rd_data;

    skt_pkg::ord_t rd_ord;
    logic          cmp_eq, cmp_lt, srch_done;
    logic [CW-1:0] cur_ext;
    logic          is_insert, is_remove, out_free, tbl_full;
    logic [AW-1:0] hv_lo, hv_hi, hv_diff;

    function automatic logic [8:0] OUT_W9(input logic [CW-1:0] v);
        return skt_pkg::OUT_IDX_W'(v);
    endfunction

    skt_ram #(
        .WIDTH(skt_pkg::WORD_W),
        .DEPTH(CAPACITY)
    ) u_table (
        .clk    (clk),
        .wr_en  (ram_wr_en),
        .wr_addr(ram_wr_addr),
        .wr_data(ram_wr_data),
        .rd_en  (ram_rd_en),
        .rd_addr(ram_rd_addr),
        .rd_data(ram_rd_data)
    );

    assign rd_ord    = skt_pkg::order_of(ram_rd_data[skt_pkg::WORD_W-1:skt_pkg::PAY_W]);
    assign cmp_eq    = (target_reg == rd_ord);
    assign cmp_lt    = (target_reg < rd_ord);
    assign cur_ext   = CW'(cur_reg);
    assign is_insert = (cmd_reg == skt_pkg::CMD_INSERT);
    assign is_remove = (cmd_reg == skt_pkg::CMD_REMOVE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign tbl_full  = (count_reg >= CW'(CAPACITY));
    assign hv_lo     = cmp_lt ? lo_reg : cur_reg;
    assign hv_hi     = cmp_lt ? cur_reg : hi_reg;
    assign hv_diff   = hv_hi - hv_lo;

    always_comb
    begin
        srch_done = 1'b0;
        if (cmp_eq)
        begin
            srch_done = 1'b1;
        end
        else
        begin
            case (phase_reg)
                skt_pkg::PH_HALVE: srch_done = 1'b0;
                skt_pkg::PH_LOW:   srch_done = cmp_lt || (lo_reg == hi_reg);
                skt_pkg::PH_HIGH:  srch_done = 1'b1;
                default:           srch_done = 1'b1;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            skt_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (count_reg == '0) ? skt_pkg::ST_EXEC : skt_pkg::ST_READ;
                end
            end
            skt_pkg::ST_READ:
            begin
                state_next = skt_pkg::ST_CMP;
            end
            skt_pkg::ST_CMP:
            begin
                state_next = srch_done ? skt_pkg::ST_EXEC : skt_pkg::ST_READ;
            end
            skt_pkg::ST_EXEC:
            begin
                if (is_insert && !hit_reg)
                begin
                    if (tbl_full)
                    begin
                        state_next = skt_pkg::ST_FINISH;
                    end
                    else if (pos_reg == count_reg)
                    begin
                        state_next = skt_pkg::ST_WRNEW;
                    end
                    else
                    begin
                        state_next = skt_pkg::ST_SHIFT;
                    end
                end
                else if (is_remove && hit_reg && (CW'(pos_reg + 1'b1) < count_reg))
                begin
                    state_next = skt_pkg::ST_SHIFT;
                end
                else
                begin
                    state_next = skt_pkg::ST_FINISH;
                end
            end
            skt_pkg::ST_SHIFT:
            begin
                if (sh_ptr_reg == sh_end_reg)
                begin
                    state_next = skt_pkg::ST_TAIL;
                end
            end
            skt_pkg::ST_TAIL:
            begin
                state_next = is_insert ? skt_pkg::ST_WRNEW : skt_pkg::ST_FINISH;
            end
            skt_pkg::ST_WRNEW:
            begin
                state_next = skt_pkg::ST_FINISH;
            end
            skt_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = skt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = skt_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        phase_next       = phase_reg;
        count_next       = count_reg;
        last_hit_next    = last_hit_reg;
        hint_valid_next  = hint_valid_reg;
        cmd_next         = cmd_reg;
        key_next         = key_reg;
        pay_next         = pay_reg;
        target_next      = target_reg;
        lo_next          = lo_reg;
        hi_next          = hi_reg;
        cur_next         = cur_reg;
        pos_next         = pos_reg;
        hit_next         = hit_reg;
        hit_pay_next     = hit_pay_reg;
        status_next      = status_reg;
        sh_ptr_next      = sh_ptr_reg;
        sh_end_next      = sh_end_reg;
        sh_prev_next     = sh_prev_reg;
        sh_pend_next     = sh_pend_reg;
        out_valid_next   = out_valid_reg && out_stall;
        found_next       = found_reg;
        position_next    = position_reg;
        payload_out_next = payload_out_reg;
        entry_count_next = entry_count_reg;
        status_out_next  = status_out_reg;
        ram_wr_en        = 1'b0;
        ram_wr_addr      = sh_prev_reg;
        ram_wr_data      = ram_rd_data;
        ram_rd_en        = 1'b0;
        ram_rd_addr      = cur_reg;
        in_stall         = (state_reg != skt_pkg::ST_IDLE);

        case (state_reg)
            skt_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next    = cmd;
                    key_next    = cell_key;
                    pay_next    = entry_payload;
                    target_next = skt_pkg::order_of(cell_key);
                    hit_next    = 1'b0;
                    pos_next    = '0;
                    status_next = skt_pkg::STATUS_OK;
                    phase_next  = skt_pkg::PH_HALVE;
                    lo_next     = '0;
                    hi_next     = AW'(count_reg - 1'b1);
                    if (hint_valid_reg && (CW'(last_hit_reg) < count_reg))
                    begin
                        cur_next = last_hit_reg;
                    end
                    else
                    begin
                        cur_next = AW'(count_reg - 1'b1) >> 1;
                    end
                end
            end
            skt_pkg::ST_READ:
            begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = cur_reg;
            end
            skt_pkg::ST_CMP:
            begin
                if (cmp_eq)
                begin
                    hit_next        = 1'b1;
                    pos_next        = cur_ext;
                    last_hit_next   = cur_reg;
                    hint_valid_next = 1'b1;
                    hit_pay_next    = ram_rd_data[skt_pkg::PAY_W-1:0];
                end
                else
                begin
                    case (phase_reg)
                        skt_pkg::PH_HALVE:
                        begin
                            lo_next = hv_lo;
                            hi_next = hv_hi;
                            if (hv_diff <= AW'(1))
                            begin
                                cur_next   = hv_lo;
                                phase_next = skt_pkg::PH_LOW;
                            end
                            else
                            begin
                                cur_next = hv_lo + (hv_diff >> 1);
                            end
                        end
                        skt_pkg::PH_LOW:
                        begin
                            if (cmp_lt)
                            begin
                                pos_next = cur_ext;
                            end
                            else if (lo_reg == hi_reg)
                            begin
                                pos_next = CW'(cur_ext + 1'b1);
                            end
                            else
                            begin
                                phase_next = skt_pkg::PH_HIGH;
                                cur_next   = hi_reg;
                            end
                        end
                        default:
                        begin
                            pos_next = cmp_lt ? cur_ext : CW'(cur_ext + 1'b1);
                        end
                    endcase
                end
            end
            skt_pkg::ST_EXEC:
            begin
                sh_pend_next = 1'b0;
                if (is_insert && !hit_reg)
                begin
                    if (tbl_full)
                    begin
                        status_next = skt_pkg::STATUS_FULL;
                    end
                    sh_ptr_next = AW'(count_reg - 1'b1);
                    sh_end_next = AW'(pos_reg);
                end
                else if (is_remove && hit_reg)
                begin
                    sh_ptr_next = AW'(pos_reg + 1'b1);
                    sh_end_next = AW'(count_reg - 1'b1);
                    count_next  = CW'(count_reg - 1'b1);
                end
            end
            skt_pkg::ST_SHIFT:
            begin
                ram_rd_en    = 1'b1;
                ram_rd_addr  = sh_ptr_reg;
                ram_wr_en    = sh_pend_reg;
                ram_wr_addr  = is_insert ? AW'(sh_prev_reg + 1'b1) : AW'(sh_prev_reg - 1'b1);
                sh_pend_next = 1'b1;
                sh_prev_next = sh_ptr_reg;
                sh_ptr_next  = is_insert ? AW'(sh_ptr_reg - 1'b1) : AW'(sh_ptr_reg + 1'b1);
            end
            skt_pkg::ST_TAIL:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = is_insert ? AW'(sh_prev_reg + 1'b1) : AW'(sh_prev_reg - 1'b1);
            end
            skt_pkg::ST_WRNEW:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = AW'(pos_reg);
                ram_wr_data = {key_reg, pay_reg};
                count_next  = CW'(count_reg + 1'b1);
            end
            skt_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    found_next       = hit_reg;
                    position_next    = OUT_W9(pos_reg);
                    payload_out_next = hit_reg ? hit_pay_reg : '0;
                    entry_count_next = OUT_W9(count_reg);
                    status_out_next  = status_reg;
                end
            end
            default:
            begin
                ram_rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= skt_pkg::ST_IDLE;
            count_reg      <= '0;
            hint_valid_reg <= 1'b0;
            sh_pend_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            hint_valid_reg <= hint_valid_next;
            sh_pend_reg    <= sh_pend_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        phase_reg       <= phase_next;
        last_hit_reg    <= last_hit_next;
        cmd_reg         <= cmd_next;
        key_reg         <= key_next;
        pay_reg         <= pay_next;
        target_reg      <= target_next;
        lo_reg          <= lo_next;
        hi_reg          <= hi_next;
        cur_reg         <= cur_next;
        pos_reg         <= pos_next;
        hit_reg         <= hit_next;
        hit_pay_reg     <= hit_pay_next;
        status_reg      <= status_next;
        sh_ptr_reg      <= sh_ptr_next;
        sh_end_reg      <= sh_end_next;
        sh_prev_reg     <= sh_prev_next;
        found_reg       <= found_next;
        position_reg    <= position_next;
        payload_out_reg <= payload_out_next;
        entry_count_reg <= entry_count_next;
        status_out_reg  <= status_out_next;
    end

    assign out_valid   = out_valid_reg;
    assign found       = found_reg;
    assign position    = position_reg;
    assign payload_out = payload_out_reg;
    assign entry_count = entry_count_reg;
    assign status      = status_out_reg;

endmodule

`default_nettype wire

>>> dv/tb_sorted_key_table_search_insert_remove_unit.sv
// Self-checking testbench for sorted_key_table_search_insert_remove_unit.
// Depends on skt_pkg and the unit's RTL; a scoreboard class predicts every result transaction.
`timescale 1ns / 1ps

module tb_sorted_key_table_search_insert_remove_unit;

    localparam int TABLE_DEPTH = 256;
    localparam int PROBE_LIMIT = 128;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE_CYCLES = 300;
    localparam logic [1:0] CMD_RESERVED = 2'd3;

    typedef struct packed {
        logic        found;
        logic [8:0]  position;
        logic [31:0] payload;
        logic [8:0]  count;
        logic        status;
    } table_result_t;

    typedef enum int {KS_PRESENT, KS_TWIN, KS_NEAR, KS_SMALL, KS_FRESH} key_style_t;

    class key_table_board;
        bit [31:0]     keys [TABLE_DEPTH];
        bit [31:0]     pays [TABLE_DEPTH];
        int unsigned   n_valid;
        int unsigned   hint;
        bit            hint_ok;
        table_result_t expected_q [$];
        int unsigned   mismatches;
        int unsigned   shown;

        function longint order_key(bit [31:0] k);
            longint v;
            v = longint'(k[30:0]);
            return k[31] ? -v : v;
        endfunction

        function bit locate(bit [31:0] k, output int unsigned pos);
            int unsigned     lo;
            int unsigned     hi;
            int unsigned     cur;
            int unsigned     n;
            skt_pkg::phase_t stage;
            longint          goal;
            longint          diff;
            goal = order_key(k);
            pos = 0;
            if (n_valid == 0)
                return 1'b0;
            lo = 0;
            hi = n_valid - 1;
            stage = skt_pkg::PH_HALVE;
            cur = (hint_ok && hint <= hi) ? hint : hi / 2;
            for (n = 0; n < PROBE_LIMIT; n++)
            begin
                diff = goal - order_key(keys[cur]);
                if (diff == 0)
                begin
                    pos = cur;
                    hint = cur;
                    hint_ok = 1'b1;
                    return 1'b1;
                end
                if (stage == skt_pkg::PH_HALVE)
                begin
                    if (diff < 0)
                        hi = cur;
                    else
                        lo = cur;
                    if (hi - lo <= 1)
                    begin
                        cur = lo;
                        stage = skt_pkg::PH_LOW;
                    end
                    else
                        cur = lo + (hi - lo) / 2;
                end
                else if (stage == skt_pkg::PH_LOW)
                begin
                    if (diff < 0)
                    begin
                        pos = cur;
                        return 1'b0;
                    end
                    if (lo == hi)
                    begin
                        pos = cur + 1;
                        return 1'b0;
                    end
                    stage = skt_pkg::PH_HIGH;
                    cur = hi;
                end
                else
                begin
                    pos = (diff < 0) ? cur : cur + 1;
                    return 1'b0;
                end
            end
            pos = lo;
            return 1'b0;
        endfunction

        function void note_input(logic [1:0] op, bit [31:0] k, bit [31:0] p);
            table_result_t r;
            int unsigned   pos;
            int unsigned   i;
            bit            hit;
            hit = locate(k, pos);
            r = '0;
            r.found = hit;
            r.position = pos[8:0];
            r.payload = (hit && pos < TABLE_DEPTH) ? pays[pos] : 32'd0;
            r.status = skt_pkg::STATUS_OK;
            if (op == skt_pkg::CMD_INSERT && !hit)
            begin
                if (n_valid >= TABLE_DEPTH || pos > n_valid)
                    r.status = skt_pkg::STATUS_FULL;
                else
                begin
                    for (i = n_valid; i > pos; i--)
                    begin
                        keys[i] = keys[i-1];
                        pays[i] = pays[i-1];
                    end
                    keys[pos] = k;
                    pays[pos] = p;
                    n_valid++;
                end
            end
            else if (op == skt_pkg::CMD_REMOVE && hit && pos < n_valid)
            begin
                for (i = pos; i + 1 < n_valid; i++)
                begin
                    keys[i] = keys[i+1];
                    pays[i] = pays[i+1];
                end
                n_valid--;
            end
            r.count = n_valid[8:0];
            expected_q.push_back(r);
        endfunction

        function void flag(string field, logic [31:0] exp_val, logic [31:0] act_val);
            mismatches++;
            if (shown < 40)
            begin
                shown++;
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_val,
                         act_val);
            end
        endfunction

        function void check_result(logic f, logic [8:0] p, logic [31:0] pl, logic [8:0] c,
                                   logic s);
            table_result_t e;
            if (expected_q.size() == 0)
            begin
                flag("unexpected transaction, found", 32'hx, {31'd0, f});
                return;
            end
            e = expected_q.pop_front();
            if (f !== e.found)
                flag("found", {31'd0, e.found}, {31'd0, f});
            if (p !== e.position)
                flag("position", {23'd0, e.position}, {23'd0, p});
            if (pl !== e.payload)
                flag("payload_out", e.payload, pl);
            if (c !== e.count)
                flag("entry_count", {23'd0, e.count}, {23'd0, c});
            if (s !== e.status)
                flag("status", {31'd0, e.status}, {31'd0, s});
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  cmd = skt_pkg::CMD_LOOKUP;
    logic [31:0] cell_key = 32'd0;
    logic [31:0] entry_payload = 32'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        found;
    logic [8:0]  position;
    logic [31:0] payload_out;
    logic [8:0]  entry_count;
    logic        status;

    key_table_board board;
    bit             steady = 1'b0;
    int unsigned    cycles = 0;

    sorted_key_table_search_insert_remove_unit #(
        .CAPACITY(TABLE_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .cmd(cmd),
        .cell_key(cell_key),
        .entry_payload(entry_payload),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .found(found),
        .position(position),
        .payload_out(payload_out),
        .entry_count(entry_count),
        .status(status)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb_sorted_key_table_search_insert_remove_unit: FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_result(found, position, payload_out, entry_count, status);
    end

    initial
    begin
        int unsigned burst_left;
        bit          level;
        burst_left = 0;
        level = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (burst_left == 0)
            begin
                if ($urandom_range(0, 99) < 55)
                begin
                    level = 1'b0;
                    burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                             : $urandom_range(1, 12);
                end
                else
                begin
                    level = 1'b1;
                    burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                             : $urandom_range(1, 4);
                end
            end
            else
                burst_left--;
            out_stall <= steady ? 1'b0 : level;
        end
    end

    function automatic int unsigned next_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady || r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    function automatic bit [31:0] pick_key(key_style_t style);
        bit [31:0] k;
        if (board.n_valid == 0 && style != KS_SMALL)
            style = KS_FRESH;
        case (style)
            KS_SMALL: k = {1'($urandom_range(0, 1)), 31'($urandom_range(0, 24))};
            KS_FRESH: k = $urandom;
            default:
            begin
                k = board.keys[$urandom_range(0, board.n_valid - 1)];
                if (style == KS_TWIN)
                    k[31] = ~k[31];
                else if (style == KS_NEAR)
                    k = $urandom_range(0, 1) ? k + 32'd1 : k - 32'd1;
            end
        endcase
        return k;
    endfunction

    function automatic key_style_t mixed_style();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return KS_PRESENT;
        if (r < 45)
            return KS_TWIN;
        if (r < 60)
            return KS_NEAR;
        if (r < 80)
            return KS_SMALL;
        return KS_FRESH;
    endfunction

    task automatic send_item(input logic [1:0] op, input bit [31:0] k, input bit [31:0] p);
        int unsigned gap;
        gap = next_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= op;
        cell_key <= k;
        entry_payload <= p;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_input(op, k, p);
    endtask

    task automatic wait_all_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    task automatic run_mixed(input int unsigned count);
        int unsigned n;
        int unsigned r;
        logic [1:0]  op;
        for (n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 30)
                op = skt_pkg::CMD_LOOKUP;
            else if (r < 70)
                op = skt_pkg::CMD_INSERT;
            else if (r < 95)
                op = skt_pkg::CMD_REMOVE;
            else
                op = CMD_RESERVED;
            send_item(op, pick_key(mixed_style()), $urandom);
        end
    endtask

    initial
    begin
        int unsigned guard;
        int unsigned r;
        board = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(skt_pkg::CMD_LOOKUP, 32'h0000_0000, 32'h1111_1111);
        send_item(skt_pkg::CMD_REMOVE, 32'h1234_5678, 32'h2222_2222);
        send_item(skt_pkg::CMD_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
        send_item(skt_pkg::CMD_LOOKUP, 32'h8000_0000, 32'h0000_0000);
        send_item(skt_pkg::CMD_INSERT, 32'h8000_0000, 32'h0000_0000);
        send_item(skt_pkg::CMD_INSERT, 32'h7FFF_FFFF, 32'hA5A5_A5A5);
        send_item(skt_pkg::CMD_INSERT, 32'hFFFF_FFFF, 32'h5A5A_5A5A);
        send_item(skt_pkg::CMD_INSERT, 32'h8000_0001, 32'h0F0F_0F0F);
        send_item(skt_pkg::CMD_INSERT, 32'h0000_0001, 32'hF0F0_F0F0);
        send_item(CMD_RESERVED, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_item(skt_pkg::CMD_LOOKUP, 32'hFFFF_FFFE, 32'h0000_0000);
        send_item(skt_pkg::CMD_REMOVE, 32'h8000_0000, 32'h0000_0000);
        send_item(skt_pkg::CMD_REMOVE, 32'h0000_0000, 32'h0000_0000);
        send_item(skt_pkg::CMD_LOOKUP, 32'h7FFF_FFFF, 32'h0000_0000);
        send_item(skt_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000);
        send_item(skt_pkg::CMD_REMOVE, 32'h7FFF_FFFF, 32'h0000_0000);
        send_item(skt_pkg::CMD_INSERT, 32'h5555_5555, 32'h3333_3333);
        send_item(CMD_RESERVED, 32'hAAAA_AAAA, 32'hCCCC_CCCC);
        wait_all_results();

        steady = 1'b1;
        run_mixed(80);
        steady = 1'b0;
        run_mixed(220);
        wait_all_results();

        guard = 0;
        while (board.n_valid < TABLE_DEPTH && guard < 600)
        begin
            guard++;
            if ($urandom_range(0, 99) < 85)
                send_item(skt_pkg::CMD_INSERT,
                          pick_key($urandom_range(0, 9) == 0 ? KS_NEAR : KS_FRESH), $urandom);
            else
                send_item(skt_pkg::CMD_LOOKUP, pick_key(KS_PRESENT), $urandom);
        end

        for (guard = 0; guard < 30; guard++)
        begin
            r = $urandom_range(0, 99);
            if (r < 50)
                send_item(skt_pkg::CMD_INSERT, pick_key(KS_FRESH), $urandom);
            else if (r < 70)
                send_item(skt_pkg::CMD_INSERT, pick_key(KS_PRESENT), $urandom);
            else if (r < 85)
                send_item(skt_pkg::CMD_LOOKUP, pick_key(mixed_style()), $urandom);
            else if (r < 90)
                send_item(CMD_RESERVED, pick_key(KS_PRESENT), $urandom);
            else
                send_item(skt_pkg::CMD_REMOVE, pick_key(KS_PRESENT), $urandom);
        end

        guard = 0;
        while (board.n_valid > 16 && guard < 400)
        begin
            guard++;
            r = $urandom_range(0, 99);
            if (r < 85)
                send_item(skt_pkg::CMD_REMOVE, pick_key(KS_PRESENT), $urandom);
            else if (r < 93)
                send_item(skt_pkg::CMD_REMOVE, pick_key(KS_FRESH), $urandom);
            else
                send_item(skt_pkg::CMD_LOOKUP, pick_key(mixed_style()), $urandom);
        end

        run_mixed(40);

        wait_all_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("tb_sorted_key_table_search_insert_remove_unit: PASS");
        else
            $display("tb_sorted_key_table_search_insert_remove_unit: FAIL");
        $finish;
    end

endmodule
